[design/llcs_pkg.sv]
// ----------------------------------------------------------------------------
// llcs_pkg
// Shared types, constants and the elaboration-time log table builder for the
// luma logarithmic contrast stretch core.
// ----------------------------------------------------------------------------
`default_nettype none

package llcs_pkg;

   // Pixel and action widths
   localparam int ChanW = 8;
   localparam int ActW  = 2;

   // Action codes
   typedef enum logic [ActW-1:0] {
      ACT_CLEAR     = 2'd0,
      ACT_MEASURE   = 2'd1,
      ACT_TRANSFORM = 2'd2
   } action_type;

   // Log table: ln(k+1) with LogFracBits fraction bits, four integer bits
   localparam int LogFracBits = 16;
   localparam int LogIntBits  = 4;
   localparam int LogFracMax  = 24;
   localparam int LogMaxW     = LogFracMax + LogIntBits;
   localparam int LogDepth    = 256;
   localparam int SeriesBits  = 56;

   // Color matrix coefficients, Q1.15 (inverse ones wider)
   localparam int CoefW = 18;
   localparam logic signed [CoefW-1:0] CoefYB = 18'sd3736;
   localparam logic signed [CoefW-1:0] CoefYG = 18'sd19235;
   localparam logic signed [CoefW-1:0] CoefYR = 18'sd9798;
   localparam logic signed [CoefW-1:0] CoefUB = 18'sd14320;
   localparam logic signed [CoefW-1:0] CoefUG = -18'sd9470;
   localparam logic signed [CoefW-1:0] CoefUR = -18'sd4850;
   localparam logic signed [CoefW-1:0] CoefVB = -18'sd3277;
   localparam logic signed [CoefW-1:0] CoefVG = -18'sd16876;
   localparam logic signed [CoefW-1:0] CoefVR = 18'sd20152;
   localparam logic signed [CoefW-1:0] CoefBU = 18'sd66585;
   localparam logic signed [CoefW-1:0] CoefGU = -18'sd12943;
   localparam logic signed [CoefW-1:0] CoefGV = -18'sd19038;
   localparam logic signed [CoefW-1:0] CoefRV = 18'sd37356;

   // Datapath widths
   localparam int UvW     = 24;            // U and V with 15 fraction bits
   localparam int ProdW   = UvW + CoefW;
   localparam int AccW    = 44;            // outputs carry 30 fraction bits
   localparam int LumaAccW = 24;           // luma sum before rounding
   localparam int FracW   = 15;
   localparam int QuoW    = ChanW + FracW; // new luma, Q8.15
   localparam int OutShift = 30;

   // Unsigned 64-bit restoring division, elaboration use only
   function automatic logic [63:0] llcs_udiv(input logic [63:0] n, input logic [63:0] d);
      logic [64:0] r;
      logic [63:0] q;
      r = '0;
      q = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[63:0], n[i]};
         if (r >= {1'b0, d}) begin
            r    = r - {1'b0, d};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // 2*atanh(1/(2i+1)) = ln((i+1)/i), scaled by 2^SeriesBits
   function automatic logic [63:0] llcs_ln_ratio(input logic [63:0] i);
      logic [63:0] d;
      logic [63:0] t;
      logic [63:0] sum;
      logic [63:0] odd;
      d   = 64'd2 * i + 64'd1;
      t   = llcs_udiv(64'd1 << SeriesBits, d);
      sum = '0;
      odd = 64'd1;
      while (t != 64'd0) begin
         sum = sum + llcs_udiv(t, odd);
         t   = llcs_udiv(t, d * d);
         odd = odd + 64'd2;
      end
      return sum << 1;
   endfunction

   // Whole table packed, entry k at [k*LogMaxW +: LogMaxW]
   function automatic logic [LogDepth*LogMaxW-1:0] llcs_log_table(input int frac);
      logic [63:0] acc;
      logic [63:0] half;
      logic [63:0] ent;
      logic [LogDepth*LogMaxW-1:0] tab;
      acc  = '0;
      half = 64'd1 << (SeriesBits - frac - 1);
      tab  = '0;
      for (int i = 1; i < LogDepth; i++) begin
         acc = acc + llcs_ln_ratio(64'(i));
         ent = (acc + half) >> (SeriesBits - frac);
         tab[i*LogMaxW +: LogMaxW] = ent[LogMaxW-1:0];
      end
      return tab;
   endfunction

endpackage

`default_nettype wire

[design/llcs_req_if.sv]
// ----------------------------------------------------------------------------
// llcs_req_if
// Request channel: action and BGR pixel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface llcs_req_if;
   import llcs_pkg::*;

   logic             valid;
   logic             ready;
   logic [ActW-1:0]  action;
   logic [ChanW-1:0] blue;
   logic [ChanW-1:0] green;
   logic [ChanW-1:0] red;

   modport source (output valid, output action, output blue, output green, output red,
                   input ready);
   modport sink   (input valid, input action, input blue, input green, input red,
                   output ready);
endinterface

`default_nettype wire

[design/llcs_rsp_if.sv]
// ----------------------------------------------------------------------------
// llcs_rsp_if
// Response channel: transformed BGR pixel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface llcs_rsp_if;
   import llcs_pkg::*;

   logic             valid;
   logic             ready;
   logic [ChanW-1:0] out_blue;
   logic [ChanW-1:0] out_green;
   logic [ChanW-1:0] out_red;

   modport source (output valid, output out_blue, output out_green, output out_red,
                   input ready);
   modport sink   (input valid, input out_blue, input out_green, input out_red,
                   output ready);
endinterface

`default_nettype wire

[design/luma_log_contrast_stretch_core.sv]
// ----------------------------------------------------------------------------
// luma_log_contrast_stretch_core
// Logarithmic luma contrast stretch of BGR pixels through a YUV round trip.
// ----------------------------------------------------------------------------
// Each request beat carries an action and a BGR pixel. Clear resets the luma
// min/max when the beat is accepted. Measure converts the pixel to 8-bit luma
// and widens the running min/max. Transform remaps luma, clamped to that range,
// through 255*(ln(Y+1)-ln(Ymin+1))/(ln(Ymax+1)-ln(Ymin+1)), converts back to BGR
// with rounding and saturation and returns one response beat. It uses the
// restoring divider that produces one quotient bit per cycle, and the single
// shared 24x18 multiplier that walks the forward and inverse color matrices.
// One pixel is in work at a time; a finished response waits in its output
// register while the next request is taken. The ln table is a constant
// built at elaboration, LOG_FRAC_BITS (8..24) sets its fraction bits.
// ----------------------------------------------------------------------------
`default_nettype none

module luma_log_contrast_stretch_core #(
   parameter int LOG_FRAC_BITS = llcs_pkg::LogFracBits
) (
   input  wire logic   clock,
   input  wire logic   reset,
   llcs_req_if.sink    req_chan,
   llcs_rsp_if.source  rsp_chan
);
   import llcs_pkg::*;

   localparam int LW   = LOG_FRAC_BITS + LogIntBits;
   localparam int NW   = LW + QuoW;
   localparam int CntW = $clog2(QuoW);
   localparam int StepW = 4;
   localparam logic [StepW-1:0] StepMatLast  = 4'd8;
   localparam logic [StepW-1:0] StepOutFirst = 4'd9;
   localparam logic [StepW-1:0] StepOutLast  = 4'd12;
   localparam logic [AccW-1:0]  OutHalf      = AccW'(64'h2000_0000);
   localparam logic [LogDepth*LogMaxW-1:0] LogRom = llcs_log_table(LOG_FRAC_BITS);

   typedef enum logic [3:0] {
      S_IDLE, S_MAT, S_MWAIT, S_LUMA, S_FETCH, S_PREP, S_DIV, S_YSET,
      S_OMUL, S_OWAIT, S_OUT
   } state_type;

   typedef enum logic [2:0] {
      OPS_BLUE, OPS_GREEN, OPS_RED, OPS_U, OPS_V
   } opsel_type;

   // Constant ln table
   logic [LW-1:0] log_rom [LogDepth];
   for (genvar k = 0; k < LogDepth; k++) begin : g_rom
      assign log_rom[k] = LogRom[k*LogMaxW +: LW];
   end

   // Registers
   state_type                state_ff, state_in;
   logic [StepW-1:0]         step_ff, step_in;
   logic [CntW-1:0]          cnt_ff, cnt_in;
   logic                     xform_ff, xform_in;
   logic [ChanW-1:0]         b_ff, b_in, g_ff, g_in, r_ff, r_in;
   logic signed [ProdW-1:0]  prod_ff, prod_in;
   logic [1:0]               pdst_ff, pdst_in;
   logic                     pvld_ff, pvld_in;
   logic signed [AccW-1:0]   acc_ff [3];
   logic signed [AccW-1:0]   acc_in [3];
   logic [ChanW-1:0]         luma_min_ff, luma_min_in, luma_max_ff, luma_max_in;
   logic signed [UvW-1:0]    u_ff, u_in, v_ff, v_in;
   logic [ChanW-1:0]         yc_ff, yc_in;
   logic                     stretch_ff, stretch_in;
   logic [LW-1:0]            num_ff, num_in, den_ff, den_in;
   logic [LW-1:0]            rem_ff, rem_in;
   logic [QuoW-1:0]          quo_ff, quo_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [ChanW-1:0]         ob_ff, ob_in, og_ff, og_in, or_ff, or_in;

   // Combinational helpers
   opsel_type                opsel;
   logic signed [CoefW-1:0]  mul_c;
   logic signed [UvW-1:0]    mul_a;
   logic signed [ProdW-1:0]  mul_p;
   logic [1:0]               mul_dst;
   logic signed [AccW-1:0]   acc_sum;
   logic [LumaAccW-1:0]      y_sum;
   logic [ChanW-1:0]         y8;
   logic [LW+ChanW-1:0]      n_mul;
   logic [NW-1:0]            n_full;
   logic [LW:0]              trial;
   logic                     trial_ge;
   logic                     req_fire;

   // Saturate a Q.30 value to one byte
   function automatic logic [ChanW-1:0] to_byte(input logic signed [AccW-1:0] v);
      logic [AccW-OutShift-2:0] hi;
      hi = v[AccW-2:OutShift];
      if (v[AccW-1]) begin
         return '0;
      end else if (hi > (AccW-OutShift-1)'(255)) begin
         return '1;
      end
      return hi[ChanW-1:0];
   endfunction

   assign req_fire       = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_blue  = ob_ff;
   assign rsp_chan.out_green = og_ff;
   assign rsp_chan.out_red   = or_ff;

   // Multiplier schedule: forward matrix, then inverse matrix
   always_comb begin
      opsel   = OPS_BLUE;
      mul_c   = '0;
      mul_dst = 2'd0;
      case (step_ff)
         4'd0:    begin opsel = OPS_BLUE;  mul_c = CoefYB; mul_dst = 2'd0; end
         4'd1:    begin opsel = OPS_GREEN; mul_c = CoefYG; mul_dst = 2'd0; end
         4'd2:    begin opsel = OPS_RED;   mul_c = CoefYR; mul_dst = 2'd0; end
         4'd3:    begin opsel = OPS_BLUE;  mul_c = CoefUB; mul_dst = 2'd1; end
         4'd4:    begin opsel = OPS_GREEN; mul_c = CoefUG; mul_dst = 2'd1; end
         4'd5:    begin opsel = OPS_RED;   mul_c = CoefUR; mul_dst = 2'd1; end
         4'd6:    begin opsel = OPS_BLUE;  mul_c = CoefVB; mul_dst = 2'd2; end
         4'd7:    begin opsel = OPS_GREEN; mul_c = CoefVG; mul_dst = 2'd2; end
         4'd8:    begin opsel = OPS_RED;   mul_c = CoefVR; mul_dst = 2'd2; end
         4'd9:    begin opsel = OPS_U;     mul_c = CoefBU; mul_dst = 2'd0; end
         4'd10:   begin opsel = OPS_U;     mul_c = CoefGU; mul_dst = 2'd1; end
         4'd11:   begin opsel = OPS_V;     mul_c = CoefGV; mul_dst = 2'd1; end
         4'd12:   begin opsel = OPS_V;     mul_c = CoefRV; mul_dst = 2'd2; end
         default: begin opsel = OPS_BLUE;  mul_c = '0;     mul_dst = 2'd0; end
      endcase
   end

   // Multiplier operand select
   always_comb begin
      case (opsel)
         OPS_BLUE:  mul_a = {{(UvW-ChanW){1'b0}}, b_ff};
         OPS_GREEN: mul_a = {{(UvW-ChanW){1'b0}}, g_ff};
         OPS_RED:   mul_a = {{(UvW-ChanW){1'b0}}, r_ff};
         OPS_U:     mul_a = u_ff;
         OPS_V:     mul_a = v_ff;
         default:   mul_a = '0;
      endcase
   end

   assign mul_p   = mul_a * mul_c;
   assign acc_sum = acc_ff[pdst_ff] + AccW'(prod_ff);

   // Luma rounding and saturation
   assign y_sum = acc_ff[0][LumaAccW-1:0] + LumaAccW'(1 << (FracW - 1));
   assign y8    = (y_sum[LumaAccW-1:FracW] > (LumaAccW-FracW)'(255)) ? '1
                                                                      : y_sum[FracW+ChanW-1:FracW];

   // Dividend: 255 * 2^15 * num + den/2
   assign n_mul  = {num_ff, {ChanW{1'b0}}} - {{ChanW{1'b0}}, num_ff};
   assign n_full = {n_mul, {FracW{1'b0}}} + NW'(den_ff >> 1);

   // Restoring divider step
   assign trial    = {rem_ff, quo_ff[QuoW-1]};
   assign trial_ge = (trial >= {1'b0, den_ff});

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      xform_in     = xform_ff;
      b_in         = b_ff;
      g_in         = g_ff;
      r_in         = r_ff;
      prod_in      = prod_ff;
      pdst_in      = pdst_ff;
      pvld_in      = 1'b0;
      acc_in       = acc_ff;
      luma_min_in  = luma_min_ff;
      luma_max_in  = luma_max_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      yc_in        = yc_ff;
      stretch_in   = stretch_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      ob_in        = ob_ff;
      og_in        = og_ff;
      or_in        = or_ff;

      // accumulate the product issued last cycle
      if (pvld_ff) begin
         acc_in[pdst_ff] = acc_sum;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               b_in     = req_chan.blue;
               g_in     = req_chan.green;
               r_in     = req_chan.red;
               xform_in = (req_chan.action == ACT_TRANSFORM);
               if (req_chan.action == ACT_CLEAR) begin
                  luma_max_in = '0;
                  luma_min_in = '1;
               end else if (req_chan.action == ACT_MEASURE ||
                            req_chan.action == ACT_TRANSFORM) begin
                  acc_in[0] = '0;
                  acc_in[1] = '0;
                  acc_in[2] = '0;
                  step_in   = '0;
                  state_in  = S_MAT;
               end
            end
         end
         S_MAT: begin
            pvld_in = 1'b1;
            prod_in = mul_p;
            pdst_in = mul_dst;
            step_in = step_ff + StepW'(1);
            if (step_ff == StepMatLast) begin
               state_in = S_MWAIT;
            end
         end
         S_MWAIT: begin
            state_in = S_LUMA;
         end
         S_LUMA: begin
            if (!xform_ff) begin
               if (y8 > luma_max_ff) luma_max_in = y8;
               if (y8 < luma_min_ff) luma_min_in = y8;
               state_in = S_IDLE;
            end else begin
               u_in       = UvW'(acc_ff[1]);
               v_in       = UvW'(acc_ff[2]);
               stretch_in = (luma_max_ff > luma_min_ff);
               if (y8 < luma_min_ff) begin
                  yc_in = luma_min_ff;
               end else if (y8 > luma_max_ff) begin
                  yc_in = luma_max_ff;
               end else begin
                  yc_in = y8;
               end
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            num_in   = log_rom[yc_ff] - log_rom[luma_min_ff];
            den_in   = log_rom[luma_max_ff] - log_rom[luma_min_ff];
            state_in = S_PREP;
         end
         S_PREP: begin
            cnt_in = '0;
            if (stretch_ff && den_ff != '0) begin
               rem_in   = n_full[NW-1:QuoW];
               quo_in   = n_full[QuoW-1:0];
               state_in = S_DIV;
            end else begin
               quo_in   = '0;
               state_in = S_YSET;
            end
         end
         S_DIV: begin
            rem_in = trial_ge ? LW'(trial - {1'b0, den_ff}) : LW'(trial);
            quo_in = {quo_ff[QuoW-2:0], trial_ge};
            cnt_in = cnt_ff + CntW'(1);
            if (cnt_ff == CntW'(QuoW - 1)) begin
               state_in = S_YSET;
            end
         end
         S_YSET: begin
            acc_in[0] = AccW'({quo_ff, {FracW{1'b0}}}) + OutHalf;
            acc_in[1] = AccW'({quo_ff, {FracW{1'b0}}}) + OutHalf;
            acc_in[2] = AccW'({quo_ff, {FracW{1'b0}}}) + OutHalf;
            step_in   = StepOutFirst;
            state_in  = S_OMUL;
         end
         S_OMUL: begin
            pvld_in = 1'b1;
            prod_in = mul_p;
            pdst_in = mul_dst;
            step_in = step_ff + StepW'(1);
            if (step_ff == StepOutLast) begin
               state_in = S_OWAIT;
            end
         end
         S_OWAIT: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               ob_in        = to_byte(acc_ff[0]);
               og_in        = to_byte(acc_ff[1]);
               or_in        = to_byte(acc_ff[2]);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pvld_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         luma_max_ff  <= '0;
         luma_min_ff  <= '1;
      end else begin
         state_ff     <= state_in;
         pvld_ff      <= pvld_in;
         rsp_valid_ff <= rsp_valid_in;
         luma_max_ff  <= luma_max_in;
         luma_min_ff  <= luma_min_in;
      end
      step_ff    <= step_in;
      cnt_ff     <= cnt_in;
      xform_ff   <= xform_in;
      b_ff       <= b_in;
      g_ff       <= g_in;
      r_ff       <= r_in;
      prod_ff    <= prod_in;
      pdst_ff    <= pdst_in;
      acc_ff     <= acc_in;
      u_ff       <= u_in;
      v_ff       <= v_in;
      yc_ff      <= yc_in;
      stretch_ff <= stretch_in;
      num_ff     <= num_in;
      den_ff     <= den_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      ob_ff      <= ob_in;
      og_ff      <= og_in;
      or_ff      <= or_in;
   end

`ifndef SYNTHESIS
   // partial remainder stays below the divisor
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (rem_ff < den_ff))
      else $error("divider remainder not below divisor");

   // clamped luma keeps the log ratio at or below one
   a_num_le_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PREP && stretch_ff) |-> (num_ff <= den_ff))
      else $error("log numerator exceeds log range");

   // a clear beat restores the statistics on the next cycle
   a_clear_stats: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.action == ACT_CLEAR)
         |=> (luma_max_ff == '0 && luma_min_ff == '1))
      else $error("clear did not reset luma statistics");

   // a response beat is only loaded from the output state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("response loaded outside output state");
`endif

endmodule

`default_nettype wire

[tb/sv/tb_luma_log_contrast_stretch_core.sv]
// ----------------------------------------------------------------------------
// tb_luma_log_contrast_stretch_core
// Self-checking bench for the luma log contrast stretch core. A directed table
// covers reset state, range extremes, clamping and ignored actions. Random
// clear/measure/transform scenes follow under several idle and stall mixes.
// Every response beat is checked against an in-bench model of the core, or a typed expectation.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_luma_log_contrast_stretch_core;
   timeunit 1ns;
   timeprecision 1ps;

   import llcs_pkg::*;

   localparam logic [ActW-1:0] ActIgnored = 2'd3;
   localparam int LnFrac      = LogFracBits;
   localparam int SeriesFrac  = 56;
   localparam int ResetCycles = 10;
   localparam int TailCycles  = 100;
   localparam int HoldCycles  = 400;
   localparam int CycleLimit  = 1_000_000;
   localparam int PhaseBeats  = 320;
   localparam int MaxReported = 10;

   typedef struct packed {
      logic [ChanW-1:0] b;
      logic [ChanW-1:0] g;
      logic [ChanW-1:0] r;
   } bgr_type;

   typedef struct {
      logic [ActW-1:0]  act;
      logic [ChanW-1:0] b;
      logic [ChanW-1:0] g;
      logic [ChanW-1:0] r;
      bit               typed;
      bgr_type          pix;
   } stim_row_type;

   localparam bgr_type Black = '{8'd0, 8'd0, 8'd0};
   localparam bgr_type White = '{8'd255, 8'd255, 8'd255};

   logic clock;
   logic reset;

   llcs_req_if req_chan ();
   llcs_rsp_if rsp_chan ();

   luma_log_contrast_stretch_core #(
      .LOG_FRAC_BITS (LnFrac)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   // Model state: luma range and ln table
   logic [ChanW-1:0] luma_lo;
   logic [ChanW-1:0] luma_hi;
   logic [31:0]      ln_lut [LogDepth];

   bgr_type expected_pixels [$];
   int   fail_count;
   int   beats_counted;
   int   tx_idle_pct;
   int   rx_stall_pct;
   logic holdoff_arm;

   // Directed rows; typed expectations only where the answer is obvious
   stim_row_type dir_rows [24] = '{
      '{ACT_TRANSFORM, 8'd0,   8'd0,   8'd0,   1'b1, Black},  // no range yet
      '{ACT_TRANSFORM, 8'd128, 8'd128, 8'd128, 1'b1, Black},
      '{ACT_TRANSFORM, 8'd255, 8'd255, 8'd255, 1'b1, Black},
      '{ActIgnored,    8'd255, 8'd255, 8'd255, 1'b0, Black},
      '{ACT_MEASURE,   8'd100, 8'd100, 8'd100, 1'b0, Black},
      '{ACT_TRANSFORM, 8'd100, 8'd100, 8'd100, 1'b1, Black},  // max equals min
      '{ACT_MEASURE,   8'd0,   8'd0,   8'd0,   1'b0, Black},
      '{ACT_MEASURE,   8'd255, 8'd255, 8'd255, 1'b0, Black},
      '{ACT_TRANSFORM, 8'd255, 8'd255, 8'd255, 1'b1, White},  // full range
      '{ACT_TRANSFORM, 8'd0,   8'd0,   8'd0,   1'b1, Black},
      '{ACT_TRANSFORM, 8'd255, 8'd0,   8'd0,   1'b0, Black},
      '{ACT_TRANSFORM, 8'd0,   8'd255, 8'd0,   1'b0, Black},
      '{ACT_TRANSFORM, 8'd0,   8'd0,   8'd255, 1'b0, Black},
      '{ACT_TRANSFORM, 8'd255, 8'd255, 8'd0,   1'b0, Black},
      '{ACT_TRANSFORM, 8'd0,   8'd255, 8'd255, 1'b0, Black},
      '{ACT_CLEAR,     8'd255, 8'd255, 8'd255, 1'b0, Black},
      '{ACT_MEASURE,   8'd60,  8'd60,  8'd60,  1'b0, Black},
      '{ACT_MEASURE,   8'd170, 8'd170, 8'd170, 1'b0, Black},
      '{ACT_TRANSFORM, 8'd10,  8'd10,  8'd10,  1'b0, Black},  // below range
      '{ACT_TRANSFORM, 8'd250, 8'd250, 8'd250, 1'b0, Black},  // above range
      '{ACT_TRANSFORM, 8'd120, 8'd90,  8'd200, 1'b0, Black},
      '{ActIgnored,    8'd0,   8'd0,   8'd0,   1'b0, Black},
      '{ACT_CLEAR,     8'd0,   8'd0,   8'd0,   1'b0, Black},
      '{ACT_TRANSFORM, 8'd200, 8'd30,  8'd90,  1'b0, Black}   // cleared range
   };

   // Clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Truncate a 30-fraction-bit value to a byte, negatives to zero, above 255 to 255
   function automatic logic [ChanW-1:0] sat_byte(input longint x);
      if (x < 0)
         return '0;
      x = x >>> OutShift;
      return (x > 255) ? 8'd255 : x[ChanW-1:0];
   endfunction

   // Apply one request to the model; returns 1 when a pixel comes out
   function automatic bit stretch_step(input logic [ActW-1:0] act,
                                       input logic [ChanW-1:0] b, g, r,
                                       output bgr_type pix);
      longint bl, gl, rl, luma, u, v, ynew, y30;
      longint unsigned num, den;
      logic [ChanW-1:0] y8, yc;
      bl   = b;
      gl   = g;
      rl   = r;
      pix  = '0;
      ynew = 0;
      luma = (longint'(CoefYB) * bl + longint'(CoefYG) * gl + longint'(CoefYR) * rl
              + 16384) >>> FracW;
      y8   = (luma > 255) ? 8'd255 : luma[ChanW-1:0];
      if (act == ACT_CLEAR) begin
         luma_hi = '0;
         luma_lo = 8'd255;
         return 1'b0;
      end
      if (act == ACT_MEASURE) begin
         if (y8 > luma_hi)
            luma_hi = y8;
         if (y8 < luma_lo)
            luma_lo = y8;
         return 1'b0;
      end
      if (act != ACT_TRANSFORM)
         return 1'b0;

      u = longint'(CoefUB) * bl + longint'(CoefUG) * gl + longint'(CoefUR) * rl;
      v = longint'(CoefVB) * bl + longint'(CoefVG) * gl + longint'(CoefVR) * rl;

      // Log remap of luma within the measured range
      if (luma_hi > luma_lo) begin
         yc = y8;
         if (yc < luma_lo)
            yc = luma_lo;
         if (yc > luma_hi)
            yc = luma_hi;
         num = 64'(ln_lut[yc]) - 64'(ln_lut[luma_lo]);
         den = 64'(ln_lut[luma_hi]) - 64'(ln_lut[luma_lo]);
         if (den != 0)
            ynew = longint'((64'd255 * num * 64'd32768 + den / 2) / den);
      end

      y30   = ynew * 32768 + (longint'(1) << 29);
      pix.b = sat_byte(y30 + longint'(CoefBU) * u);
      pix.g = sat_byte(y30 + longint'(CoefGU) * u + longint'(CoefGV) * v);
      pix.r = sat_byte(y30 + longint'(CoefRV) * v);
      return 1'b1;
   endfunction

   // Channel value biased toward the extremes
   function automatic logic [ChanW-1:0] rand_chan();
      case ($urandom_range(9))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Channel value near a scene center, for narrow measured ranges
   function automatic logic [ChanW-1:0] scene_chan(input int center, input int spread);
      int val;
      val = center + int'($urandom_range(spread));
      return (val > 255) ? 8'd255 : 8'(val);
   endfunction

   // Offer one request beat, wait for acceptance, then update the model
   task automatic offer_beat(input logic [ActW-1:0] act,
                             input logic [ChanW-1:0] b, g, r,
                             input bit typed = 1'b0,
                             input bgr_type typed_pix = '0);
      bgr_type pix;
      while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.action <= act;
      req_chan.blue   <= b;
      req_chan.green  <= g;
      req_chan.red    <= r;
      do
         @(posedge clock);
      while (!req_chan.ready);
      if (act != ActIgnored)
         beats_counted++;
      if (stretch_step(act, b, g, r, pix))
         expected_pixels.push_back(typed ? typed_pix : pix);
   endtask

   // Stop offering and let every pending pixel come back
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (expected_pixels.size() != 0)
         @(posedge clock);
      repeat (TailCycles) @(posedge clock);
   endtask

   // One random phase of scenes: clear at times, measure a few, transform a few; else noise
   task automatic run_phase(input int n_beats, input int tx_pct, input int rx_pct,
                            input bit hold_rx);
      int target, center, spread, k;
      tx_idle_pct  = tx_pct;
      rx_stall_pct = rx_pct;
      target       = beats_counted + n_beats;
      while (beats_counted < target) begin
         if (hold_rx && beats_counted > target - n_beats / 2)
            holdoff_arm <= 1'b1;
         if ($urandom_range(99) < 80) begin
            if ($urandom_range(1) == 1)
               offer_beat(ACT_CLEAR, rand_chan(), rand_chan(), rand_chan());
            center = $urandom_range(255);
            case ($urandom_range(3))
               0:       spread = 0;
               1:       spread = 6;
               2:       spread = 60;
               default: spread = 255;
            endcase
            k = $urandom_range(6, 1);
            repeat (k)
               offer_beat(ACT_MEASURE, scene_chan(center, spread),
                          scene_chan(center, spread), scene_chan(center, spread));
            k = $urandom_range(8, 1);
            repeat (k)
               offer_beat(ACT_TRANSFORM, rand_chan(), rand_chan(), rand_chan());
         end else begin
            // noise: any action, any pixel
            offer_beat(ActW'($urandom_range(3)), rand_chan(), rand_chan(), rand_chan());
         end
      end
      wait_drained();
   endtask

   // Response side: ready pattern, long hold-off, and checking
   initial begin
      int      holdoff_left;
      bit      holdoff_done;
      bgr_type want;
      holdoff_left   = 0;
      holdoff_done   = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_pixels.size() == 0) begin
               fail_count++;
               if (fail_count <= MaxReported)
                  $display("%0t: unexpected beat b=%0d g=%0d r=%0d", $realtime,
                           rsp_chan.out_blue, rsp_chan.out_green, rsp_chan.out_red);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_chan.out_blue !== want.b || rsp_chan.out_green !== want.g ||
                   rsp_chan.out_red !== want.r) begin
                  fail_count++;
                  if (fail_count <= MaxReported)
                     $display("%0t: pixel mismatch exp b=%0d g=%0d r=%0d got b=%0d g=%0d r=%0d",
                              $realtime, want.b, want.g, want.r, rsp_chan.out_blue,
                              rsp_chan.out_green, rsp_chan.out_red);
               end
            end
         end
         if (holdoff_arm && !holdoff_done) begin
            holdoff_left = HoldCycles;
            holdoff_done = 1'b1;
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
         end
      end
   end

   // Run limit
   initial begin
      repeat (CycleLimit) @(posedge clock);
      $display("CHECK FAILED");
      $finish;
   end

   // Stimulus
   initial begin
      longint unsigned acc, term, d, sum, odd;
      reset           <= 1'b1;
      req_chan.valid  <= 1'b0;
      req_chan.action <= ACT_CLEAR;
      req_chan.blue   <= '0;
      req_chan.green  <= '0;
      req_chan.red    <= '0;
      holdoff_arm     <= 1'b0;
      fail_count    = 0;
      beats_counted = 0;
      tx_idle_pct   = 0;
      rx_stall_pct  = 0;
      luma_lo       = 8'd255;
      luma_hi       = '0;

      // ln(k+1) table from an atanh series with 56 fraction bits
      acc       = 0;
      ln_lut[0] = '0;
      for (int k = 1; k < LogDepth; k++) begin
         d    = 64'(2 * k + 1);
         term = (64'd1 << SeriesFrac) / d;
         sum  = 0;
         odd  = 1;
         while (term != 0) begin
            sum  += term / odd;
            term /= d * d;
            odd  += 2;
         end
         acc       += 2 * sum;
         ln_lut[k] = 32'((acc + (64'd1 << (SeriesFrac - LnFrac - 1))) >> (SeriesFrac - LnFrac));
      end

      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table
      foreach (dir_rows[i])
         offer_beat(dir_rows[i].act, dir_rows[i].b, dir_rows[i].g, dir_rows[i].r,
                    dir_rows[i].typed, dir_rows[i].pix);
      wait_drained();

      // Random phases: free running (with one long receiver hold-off),
      // sparse sender, stalling receiver, both idling
      run_phase(PhaseBeats, 0, 0, 1'b1);
      run_phase(PhaseBeats, 88, 0, 1'b0);
      run_phase(PhaseBeats, 0, 88, 1'b0);
      run_phase(PhaseBeats, 32, 32, 1'b0);

      if (fail_count == 0 && expected_pixels.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

`default_nettype wire

[filelist.f]
design/llcs_pkg.sv
design/llcs_req_if.sv
design/llcs_rsp_if.sv
design/luma_log_contrast_stretch_core.sv
tb/sv/tb_luma_log_contrast_stretch_core.sv
